### src/triangle_primitive_assembler_assert.svh
// assertion macros shared by the triangle primitive assembler rtl
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLER_ASSERT_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLER_ASSERT_SVH

// clocked check, quiet while reset is high
`define TPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define TPA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tpa_pkg.sv
// types and constants for the triangle primitive assembler
package tpa_pkg;

  // width of each stored coordinate word
  localparam int COORD_WIDTH = 64;
  // width of the coordinate ports
  localparam int PORT_WIDTH = 64;

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_VERTEX = 2'd1,
    MODE_END    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PRIM_SEPARATE = 2'd0,
    PRIM_FAN      = 2'd1,
    PRIM_STRIP    = 2'd2,
    PRIM_UNKNOWN  = 2'd3
  } prim_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] z;
  } vertex_t;

  typedef struct packed {
    vertex_t c0;
    vertex_t c1;
    vertex_t c2;
    logic    bad;
  } result_t;

endpackage

### src/triangle_primitive_assembler.sv
// Triangle primitive assembler: begin, vertex and end items in, triangles out.
// A result enters the output register, or the skid register behind a stalled one.
// Throughput: one item per cycle while in_stall is low; a two-entry output
// buffer (output plus skid register) lets inputs go on while one result waits.
// Reset (rst, synchronous) clears the type, vertex count, vertex history and buffer.
`include "triangle_primitive_assembler_assert.svh"

module triangle_primitive_assembler
  import tpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic [1:0]            primitive_type,
  input  logic [PORT_WIDTH-1:0] x,
  input  logic [PORT_WIDTH-1:0] y,
  input  logic [PORT_WIDTH-1:0] z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PORT_WIDTH-1:0] corner0_x,
  output logic [PORT_WIDTH-1:0] corner0_y,
  output logic [PORT_WIDTH-1:0] corner0_z,
  output logic [PORT_WIDTH-1:0] corner1_x,
  output logic [PORT_WIDTH-1:0] corner1_y,
  output logic [PORT_WIDTH-1:0] corner1_z,
  output logic [PORT_WIDTH-1:0] corner2_x,
  output logic [PORT_WIDTH-1:0] corner2_y,
  output logic [PORT_WIDTH-1:0] corner2_z,
  output logic                  bad_type
);

  // assembly state
  prim_t      current_type;
  logic [1:0] triple_phase;
  logic       seen_two;
  vertex_t    first_vertex;
  vertex_t    previous_vertex;
  vertex_t    older_vertex;

  // output buffer
  result_t    out_reg;
  result_t    skid_reg;
  logic       skid_valid;

  logic       in_xfer;
  logic       out_xfer;
  logic       begin_xfer;
  logic       vertex_xfer;
  logic       emit;
  logic       push;
  vertex_t    cur;
  vertex_t    first_next;
  result_t    result_next;

  // transfers
  assign in_stall    = skid_valid;
  assign in_xfer     = in_valid && !in_stall;
  assign out_xfer    = out_valid && !out_stall;
  assign begin_xfer  = in_xfer && (mode_t'(mode) == MODE_BEGIN);
  assign vertex_xfer = in_xfer && (mode_t'(mode) == MODE_VERTEX);

  // current vertex, trimmed to the stored width
  assign cur.x = x[COORD_WIDTH-1:0];
  assign cur.y = y[COORD_WIDTH-1:0];
  assign cur.z = z[COORD_WIDTH-1:0];

  // the first vertex of a primitive is captured as it arrives
  assign first_next = (triple_phase == 2'd0 && !seen_two) ? cur : first_vertex;

  // triangle selection by primitive type
  always_comb begin
    result_next.c1  = previous_vertex;
    result_next.c2  = cur;
    result_next.c0  = older_vertex;
    result_next.bad = 1'b0;
    emit            = 1'b0;
    unique case (current_type)
      PRIM_SEPARATE: begin
        emit = (triple_phase == 2'd2);
      end
      PRIM_FAN: begin
        emit           = seen_two;
        result_next.c0 = first_next;
      end
      PRIM_STRIP: begin
        emit = seen_two;
      end
      PRIM_UNKNOWN: begin
        emit            = 1'b1;
        result_next     = '0;
        result_next.bad = 1'b1;
      end
    endcase
  end

  assign push = vertex_xfer && emit;

  // assembly state update
  always_ff @(posedge clk) begin
    if (rst) begin
      current_type    <= PRIM_SEPARATE;
      triple_phase    <= 2'd0;
      seen_two        <= 1'b0;
      first_vertex    <= '0;
      previous_vertex <= '0;
      older_vertex    <= '0;
    end else if (begin_xfer) begin
      current_type <= prim_t'(primitive_type);
      triple_phase <= 2'd0;
      seen_two     <= 1'b0;
    end else if (vertex_xfer) begin
      first_vertex    <= first_next;
      older_vertex    <= previous_vertex;
      previous_vertex <= cur;
      if (triple_phase != 2'd0) begin
        seen_two <= 1'b1;
      end
      triple_phase <= (triple_phase >= 2'd2) ? 2'd0 : triple_phase + 2'd1;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_xfer) begin
        out_reg   <= result_next;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= result_next;
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  // result fields, widened to the port width
  assign corner0_x = PORT_WIDTH'(out_reg.c0.x);
  assign corner0_y = PORT_WIDTH'(out_reg.c0.y);
  assign corner0_z = PORT_WIDTH'(out_reg.c0.z);
  assign corner1_x = PORT_WIDTH'(out_reg.c1.x);
  assign corner1_y = PORT_WIDTH'(out_reg.c1.y);
  assign corner1_z = PORT_WIDTH'(out_reg.c1.z);
  assign corner2_x = PORT_WIDTH'(out_reg.c2.x);
  assign corner2_y = PORT_WIDTH'(out_reg.c2.y);
  assign corner2_z = PORT_WIDTH'(out_reg.c2.z);
  assign bad_type  = out_reg.bad;

  // checks
  `TPA_ASSERT(a_skid_behind_out, skid_valid |-> out_valid, "skid entry without output entry")
  `TPA_ASSERT(a_phase_range, triple_phase != 2'd3, "vertex phase out of range")
  `TPA_ASSERT(a_begin_clears, begin_xfer |=> (triple_phase == 2'd0 && !seen_two),
              "begin transfer did not restart the vertex count")
  `TPA_ASSERT(a_stalled_result_held, (out_valid && out_stall) |=> out_valid,
              "stalled result dropped")
  `TPA_ASSERT(a_bad_is_blank, (out_valid && bad_type) |-> (out_reg.c0 == '0 &&
              out_reg.c1 == '0 && out_reg.c2 == '0), "error result carries corner data")
  `TPA_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && !skid_valid),
                     "reset left the output buffer occupied")

endmodule

### tb/tb_triangle_primitive_assembler.sv
// self-checking testbench for the triangle primitive assembler
module tb_triangle_primitive_assembler
  import tpa_pkg::*;
();

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEMS_PER_PHASE = 430;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic [1:0]            kind;
    logic [1:0]            ptype;
    logic [PORT_WIDTH-1:0] vx;
    logic [PORT_WIDTH-1:0] vy;
    logic [PORT_WIDTH-1:0] vz;
  } stim_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            mode = MODE_END;
  logic [1:0]            primitive_type = PRIM_SEPARATE;
  logic [PORT_WIDTH-1:0] x = '0;
  logic [PORT_WIDTH-1:0] y = '0;
  logic [PORT_WIDTH-1:0] z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PORT_WIDTH-1:0] corner0_x, corner0_y, corner0_z;
  logic [PORT_WIDTH-1:0] corner1_x, corner1_y, corner1_z;
  logic [PORT_WIDTH-1:0] corner2_x, corner2_y, corner2_z;
  logic                  bad_type;

  // items waiting to be sent and triangles waiting to come out
  stim_item_t queued_items[$];
  result_t    pending_triangles[$];

  int send_idle_pct = 20;
  int recv_stall_pct = 51;
  int failures = 0;
  int items_accepted = 0;
  int triangles_seen = 0;
  int flagged_seen = 0;
  int items_generated = 0;

  // assembler state mirrored by the testbench
  prim_t      asm_type = PRIM_SEPARATE;
  logic [1:0] asm_phase = '0;
  bit         asm_seen_two = 1'b0;
  vertex_t    fan_anchor = '0;
  vertex_t    strip_prev = '0;
  vertex_t    strip_older = '0;

  triangle_primitive_assembler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .primitive_type(primitive_type), .x(x), .y(y), .z(z),
    .out_valid(out_valid), .out_stall(out_stall),
    .corner0_x(corner0_x), .corner0_y(corner0_y), .corner0_z(corner0_z),
    .corner1_x(corner1_x), .corner1_y(corner1_y), .corner1_z(corner1_z),
    .corner2_x(corner2_x), .corner2_y(corner2_y), .corner2_z(corner2_z),
    .bad_type(bad_type)
  );

  always #5 clk = ~clk;

  // advance the mirrored state by one item; returns 1 when a triangle comes out
  function automatic bit assemble_triangle(input stim_item_t it, output result_t shape);
    vertex_t now;
    vertex_t corner_a;
    bit      emit;
    shape = '0;
    emit = 1'b0;
    case (it.kind)
      MODE_BEGIN: begin
        asm_type = prim_t'(it.ptype);
        asm_phase = '0;
        asm_seen_two = 1'b0;
      end
      MODE_VERTEX: begin
        now.x = it.vx[COORD_WIDTH-1:0];
        now.y = it.vy[COORD_WIDTH-1:0];
        now.z = it.vz[COORD_WIDTH-1:0];
        if (asm_phase == 2'd0 && !asm_seen_two) fan_anchor = now;
        corner_a = strip_older;
        case (asm_type)
          PRIM_SEPARATE: emit = (asm_phase == 2'd2);
          PRIM_FAN: begin
            emit = asm_seen_two;
            corner_a = fan_anchor;
          end
          PRIM_STRIP: emit = asm_seen_two;
          default: begin
            emit = 1'b1;
            shape.bad = 1'b1;
          end
        endcase
        if (emit && !shape.bad) begin
          shape.c0 = corner_a;
          shape.c1 = strip_prev;
          shape.c2 = now;
        end
        strip_older = strip_prev;
        strip_prev = now;
        if (asm_phase != 2'd0) asm_seen_two = 1'b1;
        asm_phase = (asm_phase >= 2'd2) ? 2'd0 : asm_phase + 2'd1;
      end
      default: ;
    endcase
    return emit;
  endfunction

  task automatic compare_word(input string name, input logic [PORT_WIDTH-1:0] want,
                              input logic [PORT_WIDTH-1:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $error("%s: expected %h, actual %h", name, want, got);
    end
  endtask

  function automatic logic [PORT_WIDTH-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_item(input logic [1:0] kind, input logic [1:0] ptype,
                          input logic [PORT_WIDTH-1:0] vx, input logic [PORT_WIDTH-1:0] vy,
                          input logic [PORT_WIDTH-1:0] vz);
    stim_item_t it;
    it.kind = kind;
    it.ptype = ptype;
    it.vx = vx;
    it.vy = vy;
    it.vz = vz;
    queued_items.push_back(it);
    items_generated++;
  endtask

  task automatic add_vertex();
    add_item(MODE_VERTEX, 2'($urandom), rand_word(), rand_word(), rand_word());
  endtask

  task automatic add_begin(input prim_t ptype);
    add_item(MODE_BEGIN, ptype, rand_word(), rand_word(), rand_word());
  endtask

  task automatic add_noise();
    add_item(2'($urandom), 2'($urandom), rand_word(), rand_word(), rand_word());
  endtask

  // one primitive with random content; some are cut short or carry noise
  task automatic add_primitive();
    int    pick;
    int    count;
    prim_t ptype;
    pick = $urandom_range(0, 9);
    ptype = (pick < 3) ? PRIM_SEPARATE : (pick < 6) ? PRIM_FAN :
            (pick < 9) ? PRIM_STRIP : PRIM_UNKNOWN;
    if ($urandom_range(0, 99) < 8) add_noise();
    add_begin(ptype);
    count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 5)
        add_item(($urandom_range(0, 1) == 0) ? MODE_END : MODE_UNUSED, 2'($urandom),
                 rand_word(), rand_word(), rand_word());
      add_vertex();
    end
    if ($urandom_range(0, 99) < 85)
      add_item(MODE_END, 2'($urandom), rand_word(), rand_word(), rand_word());
  endtask

  task automatic add_directed();
    // vertices before any begin use separate triangles
    add_item(MODE_VERTEX, PRIM_UNKNOWN, '1, '0, '1);
    add_item(MODE_VERTEX, PRIM_FAN, '0, '1, '0);
    add_item(MODE_VERTEX, PRIM_STRIP, '1, '1, '1);
    // unused mode and end change nothing
    add_item(MODE_UNUSED, PRIM_FAN, '1, '1, '1);
    add_item(MODE_END, PRIM_UNKNOWN, '1, '1, '1);
    add_begin(PRIM_SEPARATE);
    repeat (3) add_vertex();
    add_begin(PRIM_FAN);
    repeat (4) add_vertex();
    add_begin(PRIM_STRIP);
    repeat (4) add_vertex();
    // unknown type flags every vertex
    add_begin(PRIM_UNKNOWN);
    add_item(MODE_VERTEX, PRIM_SEPARATE, '1, '1, '1);
    add_vertex();
    add_item(MODE_END, PRIM_SEPARATE, '0, '0, '0);
  endtask

  // wait until every item has gone in and every triangle has come out
  task automatic drain();
    do @(negedge clk);
    while (queued_items.size() != 0 || in_valid || pending_triangles.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver: present the next item once the current one has transferred
  always @(posedge clk) begin : drive
    stim_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (queued_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = queued_items.pop_front();
        in_valid <= 1'b1;
        mode <= it.kind;
        primitive_type <= it.ptype;
        x <= it.vx;
        y <= it.vy;
        z <= it.vz;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor: check each result transfer, then predict from each input transfer
  always @(posedge clk) begin : observe
    result_t    want;
    result_t    shape;
    stim_item_t it;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        triangles_seen++;
        if (bad_type === 1'b1) flagged_seen++;
        if (pending_triangles.size() == 0) begin
          failures++;
          $error("result transfer with no triangle expected");
        end else begin
          want = pending_triangles.pop_front();
          compare_word("corner0_x", PORT_WIDTH'(want.c0.x), corner0_x);
          compare_word("corner0_y", PORT_WIDTH'(want.c0.y), corner0_y);
          compare_word("corner0_z", PORT_WIDTH'(want.c0.z), corner0_z);
          compare_word("corner1_x", PORT_WIDTH'(want.c1.x), corner1_x);
          compare_word("corner1_y", PORT_WIDTH'(want.c1.y), corner1_y);
          compare_word("corner1_z", PORT_WIDTH'(want.c1.z), corner1_z);
          compare_word("corner2_x", PORT_WIDTH'(want.c2.x), corner2_x);
          compare_word("corner2_y", PORT_WIDTH'(want.c2.y), corner2_y);
          compare_word("corner2_z", PORT_WIDTH'(want.c2.z), corner2_z);
          compare_word("bad_type", PORT_WIDTH'(want.bad), PORT_WIDTH'(bad_type));
        end
      end
      if (in_valid && !in_stall) begin
        items_accepted++;
        it.kind = mode;
        it.ptype = primitive_type;
        it.vx = x;
        it.vy = y;
        it.vz = z;
        if (assemble_triangle(it, shape)) pending_triangles.push_back(shape);
      end
    end
  end

  // watchdog: no transfer on either side while work is outstanding
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else if (queued_items.size() != 0 || in_valid || pending_triangles.size() != 0) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender idles lightly, receiver stalls heavily
    send_idle_pct = 20;
    recv_stall_pct = 51;
    add_directed();
    while (items_generated < ITEMS_PER_PHASE) add_primitive();
    drain();

    // sender idles heavily, receiver stalls lightly
    send_idle_pct = 51;
    recv_stall_pct = 20;
    while (items_generated < 2 * ITEMS_PER_PHASE) add_primitive();
    drain();

    // full rate on both sides
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (items_generated < 3 * ITEMS_PER_PHASE) add_primitive();
    drain();

    $display("covered %0d input transfers and %0d triangles, %0d of them unknown type,",
             items_accepted, triangles_seen, flagged_seen);
    $display("over separate, fan, strip and unknown primitives under three stall mixes");
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
